>>> hw/rtl/modexp_pkg.sv
// modexp_pkg: shared constants, command codes and the controller/datapath
// interface types for the modular exponentiation block
// used by modexp_ctrl, modexp_dp and modular_exponentiation
package modexp_pkg;

  // fixed port widths
  localparam int BASE_W     = 64;
  localparam int EXP_PORT_W = 64;
  localparam int MOD_PORT_W = 32;
  localparam int RES_W      = 32;

  // parameter defaults
  localparam int DEF_MODULUS_WIDTH  = 32;
  localparam int DEF_EXPONENT_WIDTH = 64;

  // datapath operation codes
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE   = 3'd0;  // hold
  localparam logic [OP_W-1:0] OP_RED    = 3'd1;  // one base reduction step
  localparam logic [OP_W-1:0] OP_INIT_A = 3'd2;  // start acc * sq
  localparam logic [OP_W-1:0] OP_INIT_S = 3'd3;  // start sq * sq
  localparam logic [OP_W-1:0] OP_STEP   = 3'd4;  // one shift-add-reduce step
  localparam logic [OP_W-1:0] OP_CMT_A  = 3'd5;  // acc <= product, start sq * sq
  localparam logic [OP_W-1:0] OP_CMT_S  = 3'd6;  // sq <= product, next exponent bit

  typedef struct packed {
    logic            load;      // capture an input word
    logic [OP_W-1:0] op;
    logic            out_load;  // write the output register
  } modexp_cmd_t;

  typedef struct packed {
    logic exp_bit;   // current exponent bit
    logic exp_zero;  // no set exponent bits remain
  } modexp_status_t;

endpackage

>>> hw/rtl/modexp_dp.sv
// modexp_dp: datapath of the modular exponentiation block, operand
// registers and one shared shift-add-reduce unit
// depends on modexp_pkg
module modexp_dp #(
  parameter int MODULUS_WIDTH  = modexp_pkg::DEF_MODULUS_WIDTH,
  parameter int EXPONENT_WIDTH = modexp_pkg::DEF_EXPONENT_WIDTH
) (
  input  logic                               clk,
  input  modexp_pkg::modexp_cmd_t            cmd,
  output modexp_pkg::modexp_status_t         status,
  input  logic [modexp_pkg::BASE_W-1:0]      in_base,
  input  logic [modexp_pkg::EXP_PORT_W-1:0]  in_exponent,
  input  logic [modexp_pkg::MOD_PORT_W-1:0]  in_modulus,
  output logic [modexp_pkg::RES_W-1:0]       out_result
);

  localparam int MW    = MODULUS_WIDTH;
  localparam int EW    = EXPONENT_WIDTH;
  localparam int BW    = modexp_pkg::BASE_W;
  localparam int MIN_W = (MW < modexp_pkg::MOD_PORT_W) ? MW : modexp_pkg::MOD_PORT_W;

  logic [MW-1:0] mod_r;
  logic [BW-1:0] base_r;
  logic [EW-1:0] exp_r;
  logic [MW-1:0] acc_r;
  logic [MW-1:0] sq_r;
  logic [MW-1:0] prod_r;
  logic [MW-1:0] mul_x_r;
  logic [MW-1:0] mult_r;
  logic [modexp_pkg::RES_W-1:0] result_r;

  logic [MW-1:0] mod_in;
  logic [MW-1:0] step_a;
  logic [MW-1:0] step_add;
  logic [MW+1:0] step_s;
  logic [MW+1:0] step_d1;
  logic [MW+1:0] step_d2;
  logic [MW-1:0] step_out;

  assign mod_in = MW'(in_modulus[MIN_W-1:0]);

  // shared unit: (2a + add) mod m, inputs keep the sum below 3m
  always_comb begin
    if (cmd.op == modexp_pkg::OP_RED) begin
      step_a   = sq_r;
      step_add = MW'(base_r[BW-1]);
    end else begin
      step_a   = prod_r;
      step_add = mult_r[MW-1] ? mul_x_r : '0;
    end
    step_s  = {1'b0, step_a, 1'b0} + {2'b00, step_add};
    step_d1 = step_s - {2'b00, mod_r};
    step_d2 = step_s - {1'b0, mod_r, 1'b0};
    if (step_s >= {1'b0, mod_r, 1'b0}) begin
      step_out = step_d2[MW-1:0];
    end else if (step_s >= {2'b00, mod_r}) begin
      step_out = step_d1[MW-1:0];
    end else begin
      step_out = step_s[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r  <= mod_in;
      base_r <= in_base;
      exp_r  <= in_exponent[EW-1:0];
      sq_r   <= '0;
      // 1 mod m
      acc_r  <= MW'(mod_in != MW'(1));
    end else begin
      case (cmd.op)
        modexp_pkg::OP_RED: begin
          sq_r   <= step_out;
          base_r <= base_r << 1;
        end
        modexp_pkg::OP_INIT_A: begin
          prod_r  <= '0;
          mul_x_r <= acc_r;
          mult_r  <= sq_r;
        end
        modexp_pkg::OP_INIT_S: begin
          prod_r  <= '0;
          mul_x_r <= sq_r;
          mult_r  <= sq_r;
        end
        modexp_pkg::OP_STEP: begin
          prod_r <= step_out;
          mult_r <= mult_r << 1;
        end
        modexp_pkg::OP_CMT_A: begin
          acc_r   <= prod_r;
          prod_r  <= '0;
          mul_x_r <= sq_r;
          mult_r  <= sq_r;
        end
        modexp_pkg::OP_CMT_S: begin
          sq_r  <= prod_r;
          exp_r <= exp_r >> 1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.out_load) begin
      // zero modulus gives zero
      result_r <= (mod_r == '0) ? '0 : modexp_pkg::RES_W'(acc_r);
    end
  end

  assign status.exp_bit  = exp_r[0];
  assign status.exp_zero = (exp_r == '0);
  assign out_result      = result_r;

endmodule

>>> hw/rtl/modexp_ctrl.sv
// modexp_ctrl: controller of the modular exponentiation block, sequences
// base reduction and square-and-multiply, owns both handshakes
// depends on modexp_pkg
module modexp_ctrl #(
  parameter int MODULUS_WIDTH = modexp_pkg::DEF_MODULUS_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output modexp_pkg::modexp_cmd_t     cmd,
  input  modexp_pkg::modexp_status_t  status
);

  localparam int BW    = modexp_pkg::BASE_W;
  localparam int MAXC  = (BW > MODULUS_WIDTH) ? BW : MODULUS_WIDTH;
  localparam int CNT_W = $clog2(MAXC);

  localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(BW - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MODULUS_WIDTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_MULA = 3'd3;
  localparam logic [2:0] S_CMTA = 3'd4;
  localparam logic [2:0] S_MULS = 3'd5;
  localparam logic [2:0] S_CMTS = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.op       = modexp_pkg::OP_IDLE;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.op  = modexp_pkg::OP_RED;
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == RED_LAST) begin
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        cnt_nxt = '0;
        // stop early once the remaining exponent bits are all zero
        if (status.exp_zero) begin
          state_nxt = S_FIN;
        end else if (status.exp_bit) begin
          cmd.op    = modexp_pkg::OP_INIT_A;
          state_nxt = S_MULA;
        end else begin
          cmd.op    = modexp_pkg::OP_INIT_S;
          state_nxt = S_MULS;
        end
      end
      S_MULA: begin
        cmd.op  = modexp_pkg::OP_STEP;
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_CMTA;
        end
      end
      S_CMTA: begin
        cmd.op    = modexp_pkg::OP_CMT_A;
        cnt_nxt   = '0;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.op  = modexp_pkg::OP_STEP;
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_CMTS;
        end
      end
      S_CMTS: begin
        cmd.op    = modexp_pkg::OP_CMT_S;
        state_nxt = S_EXP;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/modular_exponentiation.sv
// modular_exponentiation: top level, base^exponent mod modulus
// depends on modexp_pkg, modexp_ctrl and modexp_dp
//
// input channel: in_valid/in_stall with in_base, in_exponent, in_modulus
// output channel: out_valid/out_stall with out_result, one word per input word
// one word is worked on at a time; in_stall is high from acceptance until
// the result has been written to the output register
// each word: accept, then 64 base reduction steps, then per exponent bit
// (up to EXPONENT_WIDTH bits, stopping after the highest set bit)
// a set bit takes a multiply of acc by sq and then a square of sq, a clear
// bit only the square; each product is committed, then the result is written
// the single shift-add-reduce unit retires one multiplier bit per cycle and
// is shared by every modular product
// the output register lets a new word be accepted while a result waits
// a result that is still stalled holds the block in its final state
// reset (synchronous, active low) drops out_valid and returns to idle
module modular_exponentiation #(
  parameter int MODULUS_WIDTH  = modexp_pkg::DEF_MODULUS_WIDTH,
  parameter int EXPONENT_WIDTH = modexp_pkg::DEF_EXPONENT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [modexp_pkg::BASE_W-1:0]      in_base,
  input  logic [modexp_pkg::EXP_PORT_W-1:0]  in_exponent,
  input  logic [modexp_pkg::MOD_PORT_W-1:0]  in_modulus,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [modexp_pkg::RES_W-1:0]       out_result
);

  modexp_pkg::modexp_cmd_t    cmd;
  modexp_pkg::modexp_status_t status;

  modexp_ctrl #(
    .MODULUS_WIDTH(MODULUS_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  modexp_dp #(
    .MODULUS_WIDTH (MODULUS_WIDTH),
    .EXPONENT_WIDTH(EXPONENT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .in_modulus (in_modulus),
    .out_result (out_result)
  );

`ifndef NO_ASSERTIONS
  // a word is captured only on an input handshake
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall))
    else $error("load without input handshake");

  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // output register never overwritten while a result is held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("held result overwritten");

  // a new result appears only from a finished computation
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid raised without a result");
`endif

endmodule
